[hdl/rdt_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the reliable delivery tracker
// no dependencies
package rdt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] REQ_SEND  = 3'd0;
  localparam logic [2:0] REQ_RECV  = 3'd1;
  localparam logic [2:0] REQ_ACK   = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_DRAIN = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  localparam logic [2:0] OC_ASSIGNED  = 3'd0;
  localparam logic [2:0] OC_ACCEPTED  = 3'd1;
  localparam logic [2:0] OC_STALE     = 3'd2;
  localparam logic [2:0] OC_DELIVERED = 3'd3;
  localparam logic [2:0] OC_FAILED    = 3'd4;
  localparam logic [2:0] OC_ACK_SEND  = 3'd5;
  localparam logic [2:0] OC_TAB_FULL  = 3'd6;
  localparam logic [2:0] OC_ACK_FULL  = 3'd7;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] sent_time;
  } entry_t;

endpackage

[hdl/rdt_pend_mem.sv]
`timescale 1ns / 1ps
// pending delivery table: one write port, one registered read port
// uses rdt_pkg::entry_t
module rdt_pend_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  rdt_pkg::entry_t   wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output rdt_pkg::entry_t   rd_data
);

  rdt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/rdt_ack_mem.sv]
`timescale 1ns / 1ps
// ack queue storage: one write port, one registered read port
// no dependencies
module rdt_ack_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/reliable_delivery_tracker_core.sv]
`timescale 1ns / 1ps
// reliable delivery tracker core, uses rdt_pkg, rdt_pend_mem and rdt_ack_mem
// send, receive and clear: one request a cycle while the output is not stalled;
//   send and receive give a registered result, valid in the cycle after accept
// ack and tick: each pending entry scanned takes a read state, then a decide state,
//   as the pending table read is registered; drain reads and emits one queued ack at a time
// sync reset clears counters, pointers and out_valid, and sets the timeout to 1000
module reliable_delivery_tracker_core #(
  parameter int PENDING_DEPTH = 16,
  parameter int ACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] seq_in,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] seq_out,
  output logic [2:0]  outcome,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int AW  = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
  localparam int ACW = $clog2(ACK_DEPTH + 1);
  localparam int NW  = rdt_pkg::RES_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_EV    = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_DR_RD = 3'd4;
  localparam logic [2:0] ST_DR_EV = 3'd5;

  logic [2:0]  state;
  logic [31:0] timeout_ticks;
  logic [31:0] next_send_seq;
  logic [31:0] expected_recv_seq;
  logic [PCW-1:0] pcnt;
  logic [ACW-1:0] acnt;
  logic [AW-1:0]  ahead;
  logic [AW-1:0]  atail;

  // scan context
  logic [2:0]     req_r;
  logic [31:0]    seq_r;
  logic [31:0]    now_r;
  logic [PCW-1:0] rd_idx;
  logic [PCW-1:0] wr_idx;
  logic [NW-1:0]  nres;
  logic [ACW-1:0] dn;
  logic [ACW-1:0] dcnt;

  // result held back until we know whether it is the final one
  logic        h_valid;
  logic [31:0] h_seq;
  logic [2:0]  h_oc;

  logic o_free;
  logic accept;

  // memory ports
  logic            pm_wr_en;
  logic [PW-1:0]   pm_wr_addr;
  rdt_pkg::entry_t pm_wr_data;
  logic            pm_rd_en;
  rdt_pkg::entry_t pm_rd_data;
  logic            am_wr_en;
  logic            am_rd_en;
  logic [31:0]     am_rd_data;

  logic rm_hit;
  logic recv_ok;

  assign cfg_ready = 1'b1;
  assign o_free    = !out_valid || !out_stall;
  assign in_stall  = !(state == ST_IDLE && o_free);
  assign accept    = in_valid && !in_stall;

  // accepted receive that gets queued
  assign recv_ok = (seq_in >= expected_recv_seq) && (acnt != ACW'(ACK_DEPTH));

  // decide whether the entry just read leaves the table
  always_comb begin
    rm_hit = 1'b0;
    if (32'(nres) < 32'(rdt_pkg::MAX_RESULTS)) begin
      if (req_r == rdt_pkg::REQ_ACK) begin
        rm_hit = (pm_rd_data.seq <= seq_r);
      end else begin
        rm_hit = ((now_r - pm_rd_data.sent_time) >= timeout_ticks);
      end
    end
  end

  // pending table port muxing: send appends, scan compacts kept entries down
  always_comb begin
    pm_wr_en   = 1'b0;
    pm_wr_addr = pcnt[PW-1:0];
    pm_wr_data.seq       = next_send_seq;
    pm_wr_data.sent_time = now_time;
    if (accept && req_type == rdt_pkg::REQ_SEND && pcnt != PCW'(PENDING_DEPTH)) begin
      pm_wr_en = 1'b1;
    end else if (state == ST_EV && !rm_hit) begin
      pm_wr_en   = 1'b1;
      pm_wr_addr = wr_idx[PW-1:0];
      pm_wr_data = pm_rd_data;
    end
  end

  assign pm_rd_en = (state == ST_RD) && (rd_idx != pcnt);
  assign am_wr_en = accept && req_type == rdt_pkg::REQ_RECV && recv_ok;
  assign am_rd_en = (state == ST_DR_RD) && (dn != dcnt);

  rdt_pend_mem #(.DEPTH(PENDING_DEPTH), .AW(PW)) u_pend (
    .clk     (clk),
    .wr_en   (pm_wr_en),
    .wr_addr (pm_wr_addr),
    .wr_data (pm_wr_data),
    .rd_en   (pm_rd_en),
    .rd_addr (rd_idx[PW-1:0]),
    .rd_data (pm_rd_data)
  );

  rdt_ack_mem #(.DEPTH(ACK_DEPTH), .AW(AW)) u_ack (
    .clk     (clk),
    .wr_en   (am_wr_en),
    .wr_addr (atail),
    .wr_data (seq_in),
    .rd_en   (am_rd_en),
    .rd_addr (ahead),
    .rd_data (am_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      timeout_ticks     <= 32'd1000;
      next_send_seq     <= '0;
      expected_recv_seq <= '0;
      pcnt              <= '0;
      acnt              <= '0;
      ahead             <= '0;
      atail             <= '0;
      h_valid           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req_r  <= req_type;
            seq_r  <= seq_in;
            now_r  <= now_time;
            rd_idx <= '0;
            wr_idx <= '0;
            nres   <= '0;
            dn     <= '0;
            h_valid <= 1'b0;
            case (req_type)
              rdt_pkg::REQ_SEND: begin
                out_valid <= 1'b1;
                seq_out   <= next_send_seq;
                last      <= 1'b1;
                if (pcnt == PCW'(PENDING_DEPTH)) begin
                  outcome <= rdt_pkg::OC_TAB_FULL;
                end else begin
                  outcome       <= rdt_pkg::OC_ASSIGNED;
                  pcnt          <= pcnt + 1'b1;
                  next_send_seq <= next_send_seq + 32'd1;
                end
              end
              rdt_pkg::REQ_RECV: begin
                out_valid <= 1'b1;
                seq_out   <= seq_in;
                last      <= 1'b1;
                if (seq_in < expected_recv_seq) begin
                  outcome <= rdt_pkg::OC_STALE;
                end else if (!recv_ok) begin
                  outcome <= rdt_pkg::OC_ACK_FULL;
                end else begin
                  outcome           <= rdt_pkg::OC_ACCEPTED;
                  expected_recv_seq <= seq_in + 32'd1;
                  acnt              <= acnt + 1'b1;
                  atail <= (atail == AW'(ACK_DEPTH - 1)) ? '0 : atail + 1'b1;
                end
              end
              rdt_pkg::REQ_ACK, rdt_pkg::REQ_TICK: begin
                state <= ST_RD;
              end
              rdt_pkg::REQ_DRAIN: begin
                if (32'(acnt) > 32'(rdt_pkg::MAX_RESULTS)) begin
                  dcnt <= ACW'(rdt_pkg::MAX_RESULTS);
                end else begin
                  dcnt <= acnt;
                end
                state <= ST_DR_RD;
              end
              rdt_pkg::REQ_CLEAR: begin
                next_send_seq     <= '0;
                expected_recv_seq <= '0;
                pcnt              <= '0;
                acnt              <= '0;
                ahead             <= '0;
                atail             <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD: begin
          // read issued this cycle, data valid in the next
          state <= (rd_idx == pcnt) ? ST_FIN : ST_EV;
        end
        ST_EV: begin
          if (!rm_hit) begin
            wr_idx <= wr_idx + 1'b1;
            rd_idx <= rd_idx + 1'b1;
            state  <= ST_RD;
          end else if (!h_valid || o_free) begin
            if (h_valid) begin
              out_valid <= 1'b1;
              seq_out   <= h_seq;
              outcome   <= h_oc;
              last      <= 1'b0;
            end
            h_valid <= 1'b1;
            h_seq   <= pm_rd_data.seq;
            if (req_r == rdt_pkg::REQ_ACK && pm_rd_data.seq == seq_r) begin
              h_oc <= rdt_pkg::OC_DELIVERED;
            end else begin
              h_oc <= rdt_pkg::OC_FAILED;
            end
            nres   <= nres + 1'b1;
            rd_idx <= rd_idx + 1'b1;
            state  <= ST_RD;
          end
        end
        ST_FIN: begin
          // flush the held result as the final one, table shrinks to kept count
          if (!h_valid || o_free) begin
            if (h_valid) begin
              out_valid <= 1'b1;
              seq_out   <= h_seq;
              outcome   <= h_oc;
              last      <= 1'b1;
            end
            h_valid <= 1'b0;
            pcnt    <= wr_idx;
            state   <= ST_IDLE;
          end
        end
        ST_DR_RD: begin
          if (dn == dcnt) begin
            acnt  <= acnt - dcnt;
            state <= ST_IDLE;
          end else begin
            state <= ST_DR_EV;
          end
        end
        ST_DR_EV: begin
          if (o_free) begin
            out_valid <= 1'b1;
            seq_out   <= am_rd_data;
            outcome   <= rdt_pkg::OC_ACK_SEND;
            last      <= (dn + 1'b1 == dcnt);
            dn        <= dn + 1'b1;
            ahead <= (ahead == AW'(ACK_DEPTH - 1)) ? '0 : ahead + 1'b1;
            state <= ST_DR_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/reliable_delivery_tracker_core_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for reliable_delivery_tracker_core: directed and random requests,
// behavioral tracker model in the bench; depends on rdt_pkg and the core only
module reliable_delivery_tracker_core_tb;

  typedef struct {
    logic [2:0]  req;
    logic [31:0] seq;
    logic [31:0] now;
  } req_word_t;

  typedef struct {
    logic [31:0] seq;
    logic [2:0]  oc;
    logic        fin;
  } result_word_t;

  localparam int TAB_DEPTH = 16;
  localparam int ACKQ_DEPTH = 16;

  // request codes with no function
  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  req_type = rdt_pkg::REQ_CLEAR;
  logic [31:0] seq_in = 0;
  logic [31:0] now_time = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] seq_out;
  logic [2:0]  outcome;
  logic        last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 0;

  reliable_delivery_tracker_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .seq_in(seq_in), .now_time(now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .seq_out(seq_out), .outcome(outcome), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // tracker model state
  logic [31:0] mdl_timeout = 1000;
  logic [31:0] mdl_next_seq = 0;
  logic [31:0] mdl_exp_seq = 0;
  logic [31:0] tab_seq [TAB_DEPTH];
  logic [31:0] tab_time [TAB_DEPTH];
  int          tab_cnt = 0;
  logic [31:0] ackq [ACKQ_DEPTH];
  int          ackq_cnt = 0;

  req_word_t    pending_words[$];
  result_word_t expected_results[$];
  int           errors = 0;
  bit           no_idle = 0;

  // stimulus generator trackers
  logic [31:0] gen_sent = 0;
  logic [31:0] gen_exp = 0;
  logic [31:0] gen_clock = 0;

  function automatic void push_result(logic [31:0] s, logic [2:0] oc);
    result_word_t r;
    r.seq = s;
    r.oc = oc;
    r.fin = 0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // drop table entry k, later entries move down
  function automatic void drop_entry(int k);
    for (int j = k; j + 1 < tab_cnt; j++) begin
      tab_seq[j] = tab_seq[j + 1];
      tab_time[j] = tab_time[j + 1];
    end
    tab_cnt--;
  endfunction

  // compute the results of one request and update the model
  function automatic void track_request(req_word_t w);
    int n;
    int k;
    int base;
    n = 0;
    k = 0;
    base = expected_results.size();
    case (w.req)
      rdt_pkg::REQ_SEND: begin
        if (tab_cnt >= TAB_DEPTH) begin
          push_result(mdl_next_seq, rdt_pkg::OC_TAB_FULL);
        end else begin
          tab_seq[tab_cnt] = mdl_next_seq;
          tab_time[tab_cnt] = w.now;
          tab_cnt++;
          push_result(mdl_next_seq, rdt_pkg::OC_ASSIGNED);
          mdl_next_seq++;
        end
        n = 1;
      end
      rdt_pkg::REQ_RECV: begin
        if (w.seq < mdl_exp_seq) begin
          push_result(w.seq, rdt_pkg::OC_STALE);
        end else if (ackq_cnt >= ACKQ_DEPTH) begin
          push_result(w.seq, rdt_pkg::OC_ACK_FULL);
        end else begin
          ackq[ackq_cnt] = w.seq;
          ackq_cnt++;
          mdl_exp_seq = w.seq + 1;
          push_result(w.seq, rdt_pkg::OC_ACCEPTED);
        end
        n = 1;
      end
      rdt_pkg::REQ_ACK: begin
        while (k < tab_cnt && n < rdt_pkg::MAX_RESULTS) begin
          if (tab_seq[k] == w.seq) begin
            push_result(tab_seq[k], rdt_pkg::OC_DELIVERED);
            drop_entry(k);
            n++;
          end else if (tab_seq[k] < w.seq) begin
            push_result(tab_seq[k], rdt_pkg::OC_FAILED);
            drop_entry(k);
            n++;
          end else begin
            k++;
          end
        end
      end
      rdt_pkg::REQ_TICK: begin
        while (k < tab_cnt && n < rdt_pkg::MAX_RESULTS) begin
          if (32'(w.now - tab_time[k]) >= mdl_timeout) begin
            push_result(tab_seq[k], rdt_pkg::OC_FAILED);
            drop_entry(k);
            n++;
          end else begin
            k++;
          end
        end
      end
      rdt_pkg::REQ_DRAIN: begin
        n = (ackq_cnt < rdt_pkg::MAX_RESULTS) ? ackq_cnt : rdt_pkg::MAX_RESULTS;
        for (int j = 0; j < n; j++) push_result(ackq[j], rdt_pkg::OC_ACK_SEND);
        for (int j = 0; j + n < ackq_cnt; j++) ackq[j] = ackq[j + n];
        ackq_cnt -= n;
      end
      rdt_pkg::REQ_CLEAR: begin
        mdl_next_seq = 0;
        mdl_exp_seq = 0;
        tab_cnt = 0;
        ackq_cnt = 0;
      end
      default: ;
    endcase
    if (n > 0) expected_results[base + n - 1].fin = 1;
  endfunction

  // driver: acceptance seen at the rising edge, next word put out at the falling edge
  bit took = 0;
  int in_gap = 0;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      track_request('{req: req_type, seq: seq_in, now: now_time});
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || took)) begin
      took = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 0;
      end else if (pending_words.size() > 0) begin
        req_word_t w;
        w = pending_words.pop_front();
        req_type <= w.req;
        seq_in <= w.seq;
        now_time <= w.now;
        in_valid <= 1;
        in_gap = no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor: compare each accepted result word with the oldest expectation
  int out_hold = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word seq_out %0d outcome %0d", seq_out, outcome);
        errors++;
      end else begin
        result_word_t e;
        e = expected_results.pop_front();
        if (seq_out !== e.seq) begin
          $error("seq_out expected %0d actual %0d", e.seq, seq_out);
          errors++;
        end
        if (outcome !== e.oc) begin
          $error("outcome expected %0d actual %0d", e.oc, outcome);
          errors++;
        end
        if (last !== e.fin) begin
          $error("last expected %0d actual %0d", e.fin, last);
          errors++;
        end
      end
      out_hold = no_idle ? 0 : $urandom_range(0, 4);
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  function automatic void add_word(logic [2:0] r, logic [31:0] s, logic [31:0] t);
    req_word_t w;
    w.req = r;
    w.seq = s;
    w.now = t;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // random request, mostly well formed around the live sequence numbers
  function automatic void add_random_word();
    int pick;
    logic [31:0] s;
    pick = $urandom_range(0, 99);
    gen_clock += $urandom_range(0, 30);
    if ($urandom_range(0, 19) == 0) gen_clock = $urandom;
    if (pick < 30) begin
      add_word(rdt_pkg::REQ_SEND, $urandom, gen_clock);
      gen_sent++;
    end else if (pick < 52) begin
      case ($urandom_range(0, 5))
        0: s = gen_exp - $urandom_range(1, 3);
        1: s = $urandom;
        default: s = gen_exp + $urandom_range(0, 2);
      endcase
      add_word(rdt_pkg::REQ_RECV, s, $urandom);
      if (s >= gen_exp) gen_exp = s + 1;
    end else if (pick < 68) begin
      s = ($urandom_range(0, 9) == 0) ? $urandom : gen_sent - $urandom_range(0, 6);
      add_word(rdt_pkg::REQ_ACK, s, $urandom);
    end else if (pick < 84) begin
      add_word(rdt_pkg::REQ_TICK, $urandom, gen_clock);
    end else if (pick < 95) begin
      add_word(rdt_pkg::REQ_DRAIN, $urandom, $urandom);
    end else if (pick < 98) begin
      add_word(rdt_pkg::REQ_CLEAR, $urandom, $urandom);
      gen_sent = 0;
      gen_exp = 0;
    end else begin
      add_word(($urandom_range(0, 1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B, $urandom, $urandom);
    end
  endfunction

  // wait until every word is out and every result is in, then let scans finish
  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mdl_timeout = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  logic [31:0] timeout_list [5] = '{32'd0, 32'd1, 32'd25, 32'd300, 32'hFFFF_FFFF};

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: fill the table past full, timeouts at reset value, ack, receives, drain, unused codes, clear
    for (int j = 0; j < 17; j++) add_word(rdt_pkg::REQ_SEND, 32'hFFFF_FFFF, j);
    add_word(rdt_pkg::REQ_TICK, 0, 999);
    add_word(rdt_pkg::REQ_TICK, 0, 1005);
    add_word(rdt_pkg::REQ_ACK, 10, 0);
    add_word(rdt_pkg::REQ_RECV, 5, 32'hFFFF_FFFF);
    add_word(rdt_pkg::REQ_RECV, 3, 0);
    add_word(rdt_pkg::REQ_RECV, 32'hFFFF_FFFF, 0);
    add_word(rdt_pkg::REQ_RECV, 0, 0);
    add_word(rdt_pkg::REQ_DRAIN, 0, 0);
    add_word(REQ_UNUSED_A, 0, 0);
    add_word(REQ_UNUSED_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(rdt_pkg::REQ_CLEAR, 0, 0);
    wait_idle();

    // zero timeout: every pending entry fails, ack queue overflow, full drain
    write_timeout(0);
    for (int j = 0; j < 17; j++) add_word(rdt_pkg::REQ_RECV, 100 + j, 0);
    add_word(rdt_pkg::REQ_DRAIN, 0, 0);
    for (int j = 0; j < 16; j++) add_word(rdt_pkg::REQ_SEND, 0, 7);
    add_word(rdt_pkg::REQ_TICK, 0, 7);
    add_word(rdt_pkg::REQ_CLEAR, 0, 0);
    wait_idle();

    // random phases across the timeout settings, one phase without idling
    for (int p = 0; p < 5; p++) begin
      write_timeout(timeout_list[p]);
      no_idle = (p == 2);
      gen_sent = mdl_next_seq;
      gen_exp = mdl_exp_seq;
      for (int j = 0; j < 24; j++) add_random_word();
      wait_idle();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

[reliable_delivery_tracker_core.f]
hdl/rdt_pkg.sv
hdl/rdt_pend_mem.sv
hdl/rdt_ack_mem.sv
hdl/reliable_delivery_tracker_core.sv
tb/reliable_delivery_tracker_core_tb.sv
